// ===== sv/rcba_pkg.sv =====
// shared types, codes and constants of the reference-counted block allocator
// no dependencies; imported by every rcba module except the generic ram
`default_nettype none

package rcba_pkg;

   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int COUNT_BITS_DEF = 16;

   localparam int OP_BITS        = 2;
   localparam int ID_BITS        = 10;
   localparam int ACTIVE_BITS    = 11;
   localparam int STATUS_BITS    = 3;
   localparam int OUT_COUNT_BITS = 16;
   localparam int ID_LIMIT       = 1024;

   typedef enum logic [OP_BITS-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RETAIN  = 2'd1,
      OP_RELEASE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK        = 3'd0,
      STS_EXHAUSTED = 3'd1,
      STS_BAD_ID    = 3'd2,
      STS_NOT_HELD  = 3'd3,
      STS_OVERFLOW  = 3'd4
   } status_type;

   // what the front decided an item is
   typedef enum logic [2:0] {
      CLS_ALLOC   = 3'd0,
      CLS_RETAIN  = 3'd1,
      CLS_RELEASE = 3'd2,
      CLS_QUERY   = 3'd3,
      CLS_BAD_ID  = 3'd4
   } cls_type;

   typedef struct packed {
      cls_type             cls;
      logic [ID_BITS-1:0]  blk_id;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic                    load;
      logic [ACTIVE_BITS-1:0]  active;
   } cfg_type;

   // pool size right after reset
   function automatic logic [ACTIVE_BITS-1:0] reset_active(input int n);
      return (n < ID_LIMIT) ? ACTIVE_BITS'(n) : ACTIVE_BITS'(ID_LIMIT);
   endfunction

endpackage

`default_nettype wire

// ===== sv/rcba_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rcba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rcba_front.sv =====
// front end: accepts request beats, classifies them, holds a two-entry queue
// depends on rcba_pkg
`default_nettype none

module rcba_front
   import rcba_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [OP_BITS-1:0]      req_operation,
   input  wire logic [ID_BITS-1:0]      req_block_id,
   input  wire logic [ACTIVE_BITS-1:0]  active,
   input  wire logic                    busy,
   input  wire logic                    take,
   output head_type                     head
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   item_type   item;

   // classify
   always_comb begin
      item.blk_id = req_block_id;
      item.cls    = CLS_BAD_ID;
      if (op_type'(req_operation) == OP_ALLOC) begin
         item.cls = CLS_ALLOC;
      end else if ({1'b0, req_block_id} < active) begin
         case (op_type'(req_operation))
            OP_RETAIN:  item.cls = CLS_RETAIN;
            OP_RELEASE: item.cls = CLS_RELEASE;
            OP_QUERY:   item.cls = CLS_QUERY;
            default:    item.cls = CLS_ALLOC;
         endcase
      end
   end

   assign req_stall = (cnt_ff == 2'd2) || busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (take) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({accept, take})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue count beyond two entries");
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      take |-> cnt_ff != 2'd0)
      else $error("back took an item from an empty queue");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> cnt_ff != 2'd0)
      else $error("accepted beat lost from queue");
`endif

endmodule

`default_nettype wire

// ===== sv/rcba_back.sv =====
// back end: clearing pass, free stack and count table updates, result register
// depends on rcba_pkg and rcba_ram
`default_nettype none

module rcba_back
   import rcba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  head_type                        head,
   output logic                            take,
   output logic                            busy,
   input  wire logic [ACTIVE_BITS-1:0]     active,
   input  cfg_type                         cfg,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [STATUS_BITS-1:0]     rsp_status,
   output logic      [ID_BITS-1:0]         rsp_result_block,
   output logic      [OUT_COUNT_BITS-1:0]  rsp_count_after,
   output logic                            rsp_is_held,
   output logic      [ACTIVE_BITS-1:0]     rsp_free_left
);

   // the pool never exceeds what the 11-bit active count can name
   localparam int STORE_DEPTH = (NUM_BLOCKS < 2048) ? NUM_BLOCKS : 2048;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [ACTIVE_BITS-1:0]   depth_ff, depth_in;
   logic [ACTIVE_BITS-1:0]   lw_ff, lw_in;
   logic [ACTIVE_BITS-1:0]   clr_ff, clr_in;
   item_type                 cur_ff, cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               sts_ff, sts_in;
   logic [ID_BITS-1:0]       blk_ff, blk_in;
   logic [OUT_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     held_ff, held_in;
   logic [ACTIVE_BITS-1:0]   free_ff, free_in;

   logic                     ref_we, ref_re;
   logic [AW-1:0]            ref_wa, ref_ra;
   logic [COUNT_BITS-1:0]    ref_wd, ref_rd;
   logic                     stk_we, stk_re;
   logic [AW-1:0]            stk_wa, stk_ra;
   logic [AW-1:0]            stk_wd, stk_rd;

   logic                     go;
   logic [AW-1:0]            id_a;
   logic [AW-1:0]            pop_blk;
   logic [COUNT_BITS-1:0]    cnt_inc, cnt_dec;

   assign go      = !rsp_valid_ff || !rsp_stall;
   assign id_a    = AW'(cur_ff.blk_id);
   assign cnt_inc = ref_rd + COUNT_BITS'(1);
   assign cnt_dec = ref_rd - COUNT_BITS'(1);
   // stack slots below the low-water mark still hold their initial ids
   assign pop_blk = (depth_ff == lw_ff) ? AW'(active - depth_ff) : stk_rd;

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      lw_in        = lw_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sts_in       = sts_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      held_in      = held_ff;
      free_in      = free_ff;
      take         = 1'b0;
      ref_we       = 1'b0;
      ref_wa       = id_a;
      ref_wd       = '0;
      ref_re       = 1'b0;
      ref_ra       = AW'(head.item.blk_id);
      stk_we       = 1'b0;
      stk_wa       = AW'(depth_ff);
      stk_wd       = id_a;
      stk_re       = 1'b0;
      stk_ra       = AW'(depth_ff - ACTIVE_BITS'(1));

      case (state_ff)
         ST_CLEAR: begin
            ref_we = 1'b1;
            ref_wa = AW'(clr_ff);
            if (clr_ff == active - ACTIVE_BITS'(1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ACTIVE_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               take     = 1'b1;
               ref_re   = 1'b1;
               stk_re   = 1'b1;
               cur_in   = head.item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               blk_in       = cur_ff.blk_id;
               sts_in       = STS_OK;
               cnt_in       = '0;
               held_in      = 1'b0;
               free_in      = depth_ff;
               case (cur_ff.cls)
                  CLS_ALLOC: begin
                     blk_in = '0;
                     if (depth_ff == '0) begin
                        sts_in = STS_EXHAUSTED;
                     end else begin
                        depth_in = depth_ff - ACTIVE_BITS'(1);
                        if (depth_ff == lw_ff) begin
                           lw_in = depth_ff - ACTIVE_BITS'(1);
                        end
                        ref_we  = 1'b1;
                        ref_wa  = pop_blk;
                        ref_wd  = COUNT_BITS'(1);
                        blk_in  = ID_BITS'(pop_blk);
                        cnt_in  = OUT_COUNT_BITS'(1);
                        held_in = 1'b1;
                        free_in = depth_ff - ACTIVE_BITS'(1);
                     end
                  end
                  CLS_QUERY: begin
                     cnt_in  = OUT_COUNT_BITS'(ref_rd);
                     held_in = (ref_rd != '0);
                  end
                  CLS_RETAIN: begin
                     if (ref_rd == '0) begin
                        sts_in = STS_NOT_HELD;
                     end else if (ref_rd == CNT_MAX) begin
                        sts_in  = STS_OVERFLOW;
                        cnt_in  = OUT_COUNT_BITS'(ref_rd);
                        held_in = 1'b1;
                     end else begin
                        ref_we  = 1'b1;
                        ref_wd  = cnt_inc;
                        cnt_in  = OUT_COUNT_BITS'(cnt_inc);
                        held_in = 1'b1;
                     end
                  end
                  CLS_RELEASE: begin
                     if (ref_rd == '0) begin
                        sts_in = STS_NOT_HELD;
                     end else begin
                        ref_we  = 1'b1;
                        ref_wd  = cnt_dec;
                        cnt_in  = OUT_COUNT_BITS'(cnt_dec);
                        held_in = (cnt_dec != '0);
                        if (cnt_dec == '0) begin
                           stk_we   = 1'b1;
                           depth_in = depth_ff + ACTIVE_BITS'(1);
                           free_in  = depth_ff + ACTIVE_BITS'(1);
                        end
                     end
                  end
                  default: begin
                     sts_in = STS_BAD_ID;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // pool rebuild on a register write
      if (cfg.load) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         depth_in = cfg.active;
         lw_in    = cfg.active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= reset_active(NUM_BLOCKS);
         lw_ff        <= reset_active(NUM_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      sts_ff  <= sts_in;
      blk_ff  <= blk_in;
      cnt_ff  <= cnt_in;
      held_ff <= held_in;
      free_ff <= free_in;
   end

   rcba_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_en   (ref_re),
      .rd_addr (ref_ra),
      .rd_data (ref_rd)
   );

   rcba_ram #(
      .WIDTH (AW),
      .DEPTH (STORE_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   assign busy             = (state_ff == ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = sts_ff;
   assign rsp_result_block = blk_ff;
   assign rsp_count_after  = cnt_ff;
   assign rsp_is_held      = held_ff;
   assign rsp_free_left    = free_ff;

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= active)
      else $error("free stack deeper than the pool");
   a_lowmark: assert property (@(posedge clock) disable iff (reset)
      lw_ff <= depth_ff)
      else $error("low-water mark above stack depth");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> !take)
      else $error("item started during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== sv/refcounted_block_allocator_top.sv =====
// top level of the reference-counted block allocator: pool-size register,
// front end and back end; depends on rcba_pkg, rcba_front, rcba_back, rcba_ram
`default_nettype none

// Pool of fixed-size blocks, each with a reference count. A request beat
// carries an operation (allocate, retain, release, or query) and a block id;
// each accepted beat gives exactly one result beat with status, block, its
// count after the operation, its held flag and the number of free blocks.
// Free blocks sit on a last-in-first-out stack; a block is held while its
// count is nonzero, so the count table alone records both. Request beats are
// classified on entry and wait in a two-entry queue; the back end takes one
// item at a time: an idle state starts the registered memory reads (count
// table and stack top), then an execute state does the update and loads the
// result register. Through that read-then-write turn of the count table
// memory it takes no new item until the last one has loaded the result
// register, and it waits in the execute state while the result side stalls.
// After reset, and after every write to csr_write_data, the back end runs a
// clearing pass over the count table, one entry per active block; req_stall
// stays high during the pass. Stack slots never touched since that rebuild
// are not written at all: a low-water mark tells which slots still hold their
// initial ids. Writes of 0 are taken as 1 and values beyond NUM_BLOCKS as
// NUM_BLOCKS. The register may only be written while no beat is in flight.

module refcounted_block_allocator_top
   import rcba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [OP_BITS-1:0]         req_operation,
   input  wire logic [ID_BITS-1:0]         req_block_id,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [STATUS_BITS-1:0]     rsp_status,
   output logic      [ID_BITS-1:0]         rsp_result_block,
   output logic      [OUT_COUNT_BITS-1:0]  rsp_count_after,
   output logic                            rsp_is_held,
   output logic      [ACTIVE_BITS-1:0]     rsp_free_left,
   // pool-size register
   input  wire logic                       csr_write_en,
   input  wire logic [ACTIVE_BITS-1:0]     csr_write_data
);

   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [ACTIVE_BITS-1:0] clamped;
   cfg_type                cfg;
   head_type               head;
   logic                   take;
   logic                   busy;

   // clamp the written pool size into 1 .. NUM_BLOCKS
   always_comb begin
      if (csr_write_data == '0) begin
         clamped = ACTIVE_BITS'(1);
      end else if (32'(csr_write_data) > NUM_BLOCKS) begin
         clamped = ACTIVE_BITS'(NUM_BLOCKS);
      end else begin
         clamped = csr_write_data;
      end
   end

   assign active_in  = csr_write_en ? clamped : active_ff;
   assign cfg.load   = csr_write_en;
   assign cfg.active = clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= reset_active(NUM_BLOCKS);
      end else begin
         active_ff <= active_in;
      end
   end

   // classification and queue
   rcba_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_block_id  (req_block_id),
      .active        (active_ff),
      .busy          (busy),
      .take          (take),
      .head          (head)
   );

   // stack, count table and result register
   rcba_back #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .take             (take),
      .busy             (busy),
      .active           (active_ff),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_block (rsp_result_block),
      .rsp_count_after  (rsp_count_after),
      .rsp_is_held      (rsp_is_held),
      .rsp_free_left    (rsp_free_left)
   );

endmodule

`default_nettype wire
